// ===== rtl/core/ecnr_pkg.sv =====
// Shared types and constants for the edge-coupled neighbor resolver.
// No dependencies; imported by ecnr_rem and the core module.
package ecnr_pkg;

  localparam int MAX_GRIDS = 16;
  localparam int MAX_SIDE  = 256;

  // Width of a cell index along an edge (sides up to 511).
  localparam int IDX_W = 9;

  localparam logic [8:0] GRID_SIDE_RST = 9'd64;
  localparam logic [1:0] KIND_MAX      = 2'd2;

  typedef enum logic [1:0] {
    FUNC_RESOLVE = 2'd0,
    FUNC_ADD     = 2'd1,
    FUNC_CLEAR   = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_INSIDE  = 3'd0,
    ST_CROSSED = 3'd1,
    ST_MISS    = 3'd2,
    ST_ADDED   = 3'd3,
    ST_FULL    = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    BORDER_TOP    = 2'd0,
    BORDER_BOTTOM = 2'd1,
    BORDER_LEFT   = 2'd2,
    BORDER_RIGHT  = 2'd3
  } edge_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MAP,
    S_DONE
  } ecnr_state_t;

  // One connection as stored in the link RAM.
  typedef struct packed {
    logic [1:0] from_kind;
    logic [3:0] from_grid;
    edge_t      from_border;
    logic [1:0] to_kind;
    logic [3:0] to_grid;
    edge_t      to_border;
  } ecnr_link_t;

  // Input tdata layout, last field (source_type) in the low bits.
  typedef struct packed {
    logic [3:0] pad;
    logic [1:0] target_edge_in;
    logic [3:0] target_grid_in;
    logic [1:0] target_type_in;
    logic [1:0] offset_y;
    logic [1:0] offset_x;
    logic [7:0] cell_y;
    logic [7:0] cell_x;
    logic [1:0] source_edge;
    logic [3:0] source_grid;
    logic [1:0] source_type;
  } ecnr_in_t;

  // Output tdata layout.
  typedef struct packed {
    logic [1:0] pad;
    logic [7:0] found_y;
    logic [7:0] found_x;
    logic [3:0] found_grid;
    logic [1:0] found_type;
  } ecnr_out_t;

endpackage

// ===== rtl/core/ecnr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ecnr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ecnr_rem.sv =====
// Iterative remainder unit: one restoring step per cycle, IDX_W steps.
// Depends on ecnr_pkg.
module ecnr_rem
  import ecnr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [IDX_W-1:0] dividend,
  input  logic [IDX_W-1:0] divisor,
  output logic             done,
  output logic [IDX_W-1:0] rem
);

  localparam int CNT_W = $clog2(IDX_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] num;
  logic [IDX_W-1:0] den;
  logic [IDX_W-1:0] r;
  logic [IDX_W:0]   r_sh;

  assign r_sh = {r, num[IDX_W-1]};
  assign done = (cnt == '0);
  assign rem  = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(IDX_W);
    end else if (!done) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      den <= divisor;
      r   <= '0;
    end else if (!done) begin
      num <= {num[IDX_W-2:0], 1'b0};
      // remainder stays below den, so the difference fits IDX_W bits
      if (r_sh >= {1'b0, den}) begin
        r <= IDX_W'(r_sh - {1'b0, den});
      end else begin
        r <= r_sh[IDX_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/core/edge_coupled_neighbor_resolver_core.sv =====
// Edge-coupled neighbor resolver core.
// Inputs: s_* stream (func in tuser), cfg_we/cfg_data for the grid side register.
// Outputs: m_* stream with status in tuser and the found cell in tdata.
// Depends on ecnr_pkg, ecnr_ram, ecnr_rem.
//
// One beat in gives one beat out. Add, clear and resolves that do not cross an
// edge go straight to the done state, which loads the result into the output
// register and raises m_tvalid once that register is free. A resolve that
// crosses an edge scans the link RAM one entry per cycle through its registered
// read port while the remainder unit wraps the edge index in 9 steps alongside;
// a hit stops the scan and the result is mapped once the remainder is done, a
// miss ends the scan after the last entry. One item is in work at a time;
// s_tready is high only while idle.
// The result sits in an output register, so a stalled m_tready does not
// block the next input beat; a second finished result waits until the
// register frees. Reset empties the link table (count only, no clearing
// pass), sets the side to 64 and drops any pending result. The user must write
// the side register with cfg_we only while the core is idle; it is not enforced.
module edge_coupled_neighbor_resolver_core
  import ecnr_pkg::*;
#(
  parameter int MAX_LINKS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // source_type, source_grid, source_edge, cell_x, cell_y, offset_x, offset_y,
  // target_type_in, target_grid_in, target_edge_in, zero pad
  input  logic [39:0] s_tdata,
  // func
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // found_type, found_grid, found_x, found_y, zero pad
  output logic [23:0] m_tdata,
  // status
  output logic [2:0]  m_tuser
);

  localparam int AW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
  localparam int CW = $clog2(MAX_LINKS + 1);
  localparam logic [CW-1:0] LINK_CAP = CW'(MAX_LINKS);
  localparam logic [9:0] SIDE_CAP = (MAX_SIDE > 511) ? 10'd511 : 10'(MAX_SIDE);

  ecnr_state_t state, state_next;

  logic [8:0]    grid_side;
  logic [CW-1:0] link_count;
  logic [CW-1:0] ptr;
  logic          rd_pend;

  logic [1:0]    cur_type;
  logic [3:0]    cur_grid;
  edge_t         cur_edge;
  logic          cur_neg;
  ecnr_link_t    hit_link;

  status_t       res_status;
  logic [1:0]    res_type;
  logic [3:0]    res_grid;
  logic [7:0]    res_x;
  logic [7:0]    res_y;

  ecnr_in_t      in_d;
  func_t         func;
  logic          accept;
  logic          issue;
  logic          load_out;
  logic          ram_we;

  logic [8:0]    side_min;
  logic [8:0]    sz;
  logic signed [9:0] nx;
  logic signed [9:0] ny;
  logic signed [9:0] idx;
  logic [8:0]    mag;
  logic          bad_src;
  logic          in_grid;
  logic          table_full;
  logic          crossing;
  edge_t         acc_edge;

  status_t       acc_status;
  logic [1:0]    acc_type;
  logic [3:0]    acc_grid;
  logic [7:0]    acc_x;
  logic [7:0]    acc_y;

  ecnr_link_t    new_link;
  logic [15:0]   rd_data;
  ecnr_link_t    rd_link;
  logic          match;

  logic          rem_done;
  logic [8:0]    rem;
  logic [8:0]    wrap_idx;
  logic [8:0]    side_last;
  logic [7:0]    map_x;
  logic [7:0]    map_y;

  ecnr_out_t     out_d;

  assign in_d   = ecnr_in_t'(s_tdata);
  assign func   = func_t'(s_tuser);
  assign accept = s_tvalid && s_tready;

  // effective side: zero acts as one, capped at MAX_SIDE
  assign side_min = (grid_side == 9'd0) ? 9'd1 : grid_side;
  assign sz       = ({1'b0, side_min} > SIDE_CAP) ? SIDE_CAP[8:0] : side_min;
  assign side_last = sz - 9'd1;

  // neighbor classification at acceptance
  assign nx = $signed({2'b00, in_d.cell_x}) + 10'($signed(in_d.offset_x));
  assign ny = $signed({2'b00, in_d.cell_y}) + 10'($signed(in_d.offset_y));
  assign bad_src = (in_d.source_type > KIND_MAX) ||
                   ({5'd0, in_d.source_grid} >= 9'(MAX_GRIDS));
  assign in_grid = !nx[9] && (nx[8:0] < sz) && !ny[9] && (ny[8:0] < sz);
  assign table_full = (link_count >= LINK_CAP);
  assign crossing = (func == FUNC_RESOLVE) && !bad_src && !in_grid;

  always_comb begin
    if (nx[9]) begin
      acc_edge = BORDER_LEFT;
      idx      = ny;
    end else if (nx[8:0] >= sz) begin
      acc_edge = BORDER_RIGHT;
      idx      = ny;
    end else if (ny[9]) begin
      acc_edge = BORDER_TOP;
      idx      = nx;
    end else begin
      acc_edge = BORDER_BOTTOM;
      idx      = nx;
    end
  end

  assign mag = idx[9] ? 9'(-idx) : idx[8:0];

  always_comb begin
    acc_status = ST_MISS;
    acc_type   = '0;
    acc_grid   = '0;
    acc_x      = '0;
    acc_y      = '0;
    case (func)
      FUNC_RESOLVE: begin
        if (!bad_src && in_grid) begin
          acc_status = ST_INSIDE;
          acc_type   = in_d.source_type;
          acc_grid   = in_d.source_grid;
          acc_x      = nx[7:0];
          acc_y      = ny[7:0];
        end
      end
      FUNC_ADD: begin
        acc_status = table_full ? ST_FULL : ST_ADDED;
      end
      FUNC_CLEAR: begin
        acc_status = ST_CLEARED;
      end
      default: begin
        acc_status = ST_MISS;
      end
    endcase
  end

  // link RAM
  assign new_link = '{from_kind: in_d.source_type,
                      from_grid: in_d.source_grid,
                      from_border: edge_t'(in_d.source_edge),
                      to_kind: in_d.target_type_in,
                      to_grid: in_d.target_grid_in,
                      to_border: edge_t'(in_d.target_edge_in)};

  ecnr_ram #(
    .WIDTH(16),
    .DEPTH(MAX_LINKS)
  ) u_link_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(link_count[AW-1:0]),
    .wdata(new_link),
    .raddr(ptr[AW-1:0]),
    .rdata(rd_data)
  );

  assign rd_link = ecnr_link_t'(rd_data);
  assign match = rd_pend && (rd_link.from_kind == cur_type) &&
                 (rd_link.from_grid == cur_grid) && (rd_link.from_border == cur_edge);

  ecnr_rem u_rem (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .dividend(mag),
    .divisor (sz),
    .done    (rem_done),
    .rem     (rem)
  );

  // negative index wraps to side - rem
  assign wrap_idx = (cur_neg && rem != 9'd0) ? (sz - rem) : rem;

  always_comb begin
    case (hit_link.to_border)
      BORDER_TOP: begin
        map_x = wrap_idx[7:0];
        map_y = 8'd0;
      end
      BORDER_BOTTOM: begin
        map_x = wrap_idx[7:0];
        map_y = side_last[7:0];
      end
      BORDER_LEFT: begin
        map_x = 8'd0;
        map_y = wrap_idx[7:0];
      end
      BORDER_RIGHT: begin
        map_x = side_last[7:0];
        map_y = wrap_idx[7:0];
      end
      default: begin
        map_x = 8'd0;
        map_y = 8'd0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = crossing ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (match) begin
          state_next = S_MAP;
        end else if (!issue) begin
          state_next = S_DONE;
        end
      end
      S_MAP: begin
        if (rem_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    s_tready = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    ram_we   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        ram_we   = s_tvalid && (func == FUNC_ADD) && !table_full;
      end
      S_SCAN: begin
        issue = (ptr < link_count);
      end
      S_DONE: begin
        load_out = !m_tvalid || m_tready;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      grid_side  <= GRID_SIDE_RST;
      link_count <= '0;
      rd_pend    <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= issue;
      if (cfg_we) begin
        grid_side <= cfg_data;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (ram_we) begin
        link_count <= link_count + 1'b1;
      end else if (accept && func == FUNC_CLEAR) begin
        link_count <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_type   <= in_d.source_type;
      cur_grid   <= in_d.source_grid;
      cur_edge   <= acc_edge;
      cur_neg    <= idx[9];
      ptr        <= '0;
      res_status <= acc_status;
      res_type   <= acc_type;
      res_grid   <= acc_grid;
      res_x      <= acc_x;
      res_y      <= acc_y;
    end
    if (state == S_SCAN) begin
      if (issue) begin
        ptr <= ptr + 1'b1;
      end
      if (match) begin
        hit_link <= rd_link;
      end else if (!issue) begin
        res_status <= ST_MISS;
        res_type   <= '0;
        res_grid   <= '0;
        res_x      <= '0;
        res_y      <= '0;
      end
    end
    if (state == S_MAP && rem_done) begin
      res_status <= ST_CROSSED;
      res_type   <= hit_link.to_kind;
      res_grid   <= hit_link.to_grid;
      res_x      <= map_x;
      res_y      <= map_y;
    end
    if (load_out) begin
      m_tuser <= res_status;
      m_tdata <= out_d;
    end
  end

  assign out_d = '{pad: 2'b00, found_y: res_y, found_x: res_x,
                   found_grid: res_grid, found_type: res_type};

endmodule
